### rtl/pli_pkg.sv
// shared types, constants and codes of the piecewise linear interpolator
`default_nettype none
package pli_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_POINTS = 256;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W     = DATA_W + 1;
   localparam int QUO_W      = DIFF_W + FRAC_BITS;
   localparam int PROD_W     = DIFF_W + DATA_W;
   localparam int TERM_W     = PROD_W - FRAC_BITS;
   localparam int TERM_LIM_B = 40;
   localparam int SUM_W      = TERM_LIM_B + 3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   typedef struct packed {
      logic                     command;
      logic [IDX_W-1:0]         point_index;
      logic signed [DATA_W-1:0] abscissa;
      logic signed [DATA_W-1:0] ordinate;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] slope;
      logic [1:0]               status;
   } rsp_type;

   // one restoring-division step travels cell to cell in this bundle
   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [DIFF_W-1:0] dvsr;
      logic [DIFF_W-1:0] rem;
      logic [QUO_W-1:0]  bits;
   } div_lane_type;

endpackage
`default_nettype wire

### rtl/pli_div_cell.sv
// one restoring division step, registered
`default_nettype none
module pli_div_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire pli_pkg::div_lane_type lane_i,
   output pli_pkg::div_lane_type lane_o
);
   import pli_pkg::*;

   div_lane_type  lane_ff;
   div_lane_type  lane_in;
   logic [DIFF_W:0]   shifted;
   logic [DIFF_W+1:0] trial;

   always_comb begin
      shifted = {lane_i.rem, lane_i.bits[QUO_W-1]};
      trial   = {1'b0, shifted} - {2'b00, lane_i.dvsr};
      lane_in = lane_i;
      if (!trial[DIFF_W+1]) begin
         lane_in.rem  = trial[DIFF_W-1:0];
         lane_in.bits = {lane_i.bits[QUO_W-2:0], 1'b1};
      end else begin
         lane_in.rem  = shifted[DIFF_W-1:0];
         lane_in.bits = {lane_i.bits[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= lane_i.valid;
      end
      lane_ff.neg  <= lane_in.neg;
      lane_ff.dvsr <= lane_in.dvsr;
      lane_ff.rem  <= lane_in.rem;
      lane_ff.bits <= lane_in.bits;
   end

   assign lane_o = lane_ff;
endmodule
`default_nettype wire

### rtl/pli_div_chain.sv
// row of division cells, one quotient bit per cell
`default_nettype none
module pli_div_chain (
   input  wire                   clock,
   input  wire                   reset,
   input  wire pli_pkg::div_lane_type lane_i,
   output pli_pkg::div_lane_type lane_o
);
   import pli_pkg::*;

   div_lane_type link [QUO_W+1];

   assign link[0] = lane_i;

   for (genvar c = 0; c < QUO_W; c++) begin : g_cell
      pli_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .lane_i (link[c]),
         .lane_o (link[c+1])
      );
   end

   assign lane_o = link[QUO_W];
endmodule
`default_nettype wire

### rtl/piecewise_linear_interpolator.sv
// top level: breakpoint table, bracket search, divider chain and output stage
//
//  channel  direction  handshake         payload
//  req      in         req_valid/stall   pli_pkg::req_type
//  rsp      out        rsp_valid/stall   pli_pkg::rsp_type
//  csr      in         csr_we            points_in_use (9 bits)
//
// a write transaction gives no response
// a query holds the block until its response is loaded:
// the bracket search reads one table row per cycle from the single-port table,
// then the quotient ripples through one division cell per quotient bit
// one query is in flight at a time; req_stall is high from accept to response load
// a held response does not block a new transaction, only the load of the next one
// reset clears control only; table entries are undefined until written
`default_nettype none
module piecewise_linear_interpolator (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire pli_pkg::req_type   req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output pli_pkg::rsp_type        rsp_data,
   input  wire                     csr_we,
   input  wire [pli_pkg::CNT_W-1:0] csr_wdata
);
   import pli_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEARCH, ST_FETCH_L, ST_FETCH_R, ST_LOAD_R,
      ST_START, ST_WAIT, ST_MUL, ST_ADD, ST_DONE
   } state_type;

   state_type state_ff;

   // table: abscissa in the upper half of a row, ordinate in the lower
   logic [2*DATA_W-1:0] mem_ff [MAX_POINTS];
   logic [2*DATA_W-1:0] rd_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic signed [DATA_W-1:0] rd_x;
   logic signed [DATA_W-1:0] rd_y;

   logic [CNT_W-1:0]  points_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  n_in;
   logic [CNT_W-1:0]  iss_k_ff;
   logic              chk_v_ff;
   logic [IDX_W-1:0]  chk_k_ff;
   logic [IDX_W-1:0]  l_ff;
   logic              issue;
   logic              hit;

   logic signed [DATA_W-1:0] q_ff;
   logic signed [DATA_W-1:0] xl_ff;
   logic signed [DATA_W-1:0] yl_ff;
   logic signed [DIFF_W-1:0] dx_ff;
   logic signed [DIFF_W-1:0] dy_ff;
   logic signed [DIFF_W-1:0] off_ff;
   logic signed [DATA_W-1:0] slope_ff;
   logic                     sat_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [DATA_W-1:0] res_value_ff;
   logic signed [DATA_W-1:0] res_slope_ff;
   logic [1:0]               res_status_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    out_free;

   div_lane_type div_in;
   div_lane_type div_out;
   logic [DIFF_W-1:0] abs_dx;
   logic [DIFF_W-1:0] abs_dy;

   // quotient handling
   logic [QUO_W:0]           quo_s;
   logic                     quo_sat;
   logic signed [DATA_W-1:0] quo_val;

   // value path
   logic signed [TERM_W-1:0] term;
   logic signed [SUM_W-1:0]  term_c;
   logic signed [SUM_W-1:0]  sum;
   logic                     sum_hi;
   logic                     sum_lo;

   localparam logic signed [TERM_W-1:0] TermMax = TERM_W'(64'sd1 <<< TERM_LIM_B);
   localparam logic signed [SUM_W-1:0]  SumMax  = SUM_W'((64'sd1 <<< (DATA_W-1)) - 1);
   localparam logic signed [SUM_W-1:0]  SumMin  = SUM_W'(-(64'sd1 <<< (DATA_W-1)));
   localparam logic signed [DATA_W-1:0] SMax    = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SMin    = {1'b1, {(DATA_W-1){1'b0}}};

   assign rd_x = rd_ff[2*DATA_W-1:DATA_W];
   assign rd_y = rd_ff[DATA_W-1:0];

   // count clamped to the table range
   always_comb begin
      n_in = points_ff;
      if (points_ff < CNT_W'(2)) begin
         n_in = CNT_W'(2);
      end else if (points_ff > CNT_W'(MAX_POINTS)) begin
         n_in = CNT_W'(MAX_POINTS);
      end
   end

   assign issue = ({1'b0, iss_k_ff} + 1'b1) < {1'b0, n_ff};
   assign hit   = chk_v_ff && (q_ff < rd_x);

   always_comb begin
      unique case (state_ff)
         ST_FETCH_L: rd_addr = l_ff;
         ST_FETCH_R: rd_addr = l_ff + 1'b1;
         default:    rd_addr = iss_k_ff[IDX_W-1:0];
      endcase
   end

   // table port: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_data.command == CMD_WRITE) begin
         mem_ff[req_data.point_index] <= {req_data.abscissa, req_data.ordinate};
      end
      rd_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= CNT_W'(2);
      end else if (csr_we) begin
         points_ff <= csr_wdata;
      end
   end

   // divider launch
   assign abs_dx = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
   assign abs_dy = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);

   always_comb begin
      div_in.valid = (state_ff == ST_START) && (dx_ff != '0);
      div_in.neg   = dx_ff[DIFF_W-1] ^ dy_ff[DIFF_W-1];
      div_in.dvsr  = abs_dx;
      div_in.rem   = '0;
      div_in.bits  = {abs_dy, {FRAC_BITS{1'b0}}};
   end

   pli_div_chain u_div (
      .clock  (clock),
      .reset  (reset),
      .lane_i (div_in),
      .lane_o (div_out)
   );

   // truncated quotient, signed and saturated
   always_comb begin
      quo_s   = div_out.neg ? -{1'b0, div_out.bits} : {1'b0, div_out.bits};
      quo_sat = div_out.neg ? (div_out.bits > QUO_W'(64'd1 << (DATA_W-1)))
                            : (div_out.bits > QUO_W'((64'd1 << (DATA_W-1)) - 1));
      if (quo_sat) begin
         quo_val = div_out.neg ? SMin : SMax;
      end else begin
         quo_val = quo_s[DATA_W-1:0];
      end
   end

   // floor shift, clamp of the offset term, then saturating add
   always_comb begin
      term = TERM_W'(prod_ff >>> FRAC_BITS);
      if (term > TermMax) begin
         term_c = SUM_W'(TermMax);
      end else if (term < -TermMax) begin
         term_c = -SUM_W'(TermMax);
      end else begin
         term_c = SUM_W'(term);
      end
      sum    = SUM_W'(yl_ff) + term_c;
      sum_hi = sum > SumMax;
      sum_lo = sum < SumMin;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_data.command == CMD_QUERY) begin
                  q_ff     <= req_data.abscissa;
                  n_ff     <= n_in;
                  iss_k_ff <= CNT_W'(1);
                  chk_v_ff <= 1'b0;
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               // one row issued and one compared per cycle
               chk_v_ff <= issue;
               chk_k_ff <= iss_k_ff[IDX_W-1:0];
               if (issue) begin
                  iss_k_ff <= iss_k_ff + 1'b1;
               end
               if (hit) begin
                  l_ff     <= chk_k_ff - 1'b1;
                  state_ff <= ST_FETCH_L;
               end else if (!issue && !chk_v_ff) begin
                  // no bracket found: last interval, extrapolates
                  l_ff     <= IDX_W'(n_ff - CNT_W'(2));
                  state_ff <= ST_FETCH_L;
               end
            end
            ST_FETCH_L: begin
               state_ff <= ST_FETCH_R;
            end
            ST_FETCH_R: begin
               xl_ff    <= rd_x;
               yl_ff    <= rd_y;
               state_ff <= ST_LOAD_R;
            end
            ST_LOAD_R: begin
               dx_ff    <= DIFF_W'(rd_x) - DIFF_W'(xl_ff);
               dy_ff    <= DIFF_W'(rd_y) - DIFF_W'(yl_ff);
               off_ff   <= DIFF_W'(q_ff) - DIFF_W'(xl_ff);
               state_ff <= ST_START;
            end
            ST_START: begin
               if (dx_ff == '0) begin
                  // zero-width interval: slope by sign of dy, value is left ordinate
                  res_value_ff  <= yl_ff;
                  res_status_ff <= STATUS_ZERO;
                  if (dy_ff > 0) begin
                     res_slope_ff <= SMax;
                  end else if (dy_ff < 0) begin
                     res_slope_ff <= SMin;
                  end else begin
                     res_slope_ff <= '0;
                  end
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (div_out.valid) begin
                  slope_ff <= quo_val;
                  sat_ff   <= quo_sat;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= PROD_W'(off_ff) * PROD_W'(slope_ff);
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               res_slope_ff <= slope_ff;
               if (sum_hi) begin
                  res_value_ff <= SMax;
               end else if (sum_lo) begin
                  res_value_ff <= SMin;
               end else begin
                  res_value_ff <= sum[DATA_W-1:0];
               end
               res_status_ff <= (sat_ff || sum_hi || sum_lo) ? STATUS_SAT : STATUS_OK;
               state_ff      <= ST_DONE;
            end
            ST_DONE: begin
               // load the output register once the previous transaction left
               if (out_free) begin
                  rsp_ff.value  <= res_value_ff;
                  rsp_ff.slope  <= res_slope_ff;
                  rsp_ff.status <= res_status_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // divider result only appears while the sequencer waits for it
   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_out.valid |-> state_ff == ST_WAIT)
      else $error("divider result outside wait");

   // an accepted query starts the bracket search
   a_query_search: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.command == CMD_QUERY |=> state_ff == ST_SEARCH)
      else $error("query did not start search");

   // zero-width result carries an extreme or zero slope
   a_zero_slope: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_ZERO |->
         rsp_data.slope == SMax || rsp_data.slope == SMin || rsp_data.slope == '0)
      else $error("bad slope on zero-width interval");

endmodule
`default_nettype wire

### sim/pli_checker.sv
// response checker: watches the channels, predicts each query response and compares
`timescale 1ns / 1ps
module pli_checker (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_stall,
   input  pli_pkg::req_type        req_data,
   input  wire                     rsp_valid,
   input  wire                     rsp_stall,
   input  pli_pkg::rsp_type        rsp_data,
   input  wire                     csr_we,
   input  wire [pli_pkg::CNT_W-1:0] csr_wdata,
   output int                      error_count,
   output int                      answers_owed
);
   import pli_pkg::*;

   logic signed [DATA_W-1:0] abscissa_table [MAX_POINTS];
   logic signed [DATA_W-1:0] ordinate_table [MAX_POINTS];
   logic [CNT_W-1:0]         point_count;
   rsp_type                  pending_answers [$];

   localparam longint S32_MAX  = 64'sd2147483647;
   localparam longint S32_MIN  = -64'sd2147483648;
   localparam longint TERM_LIM = 64'sd1 << TERM_LIM_B;

   // expected response of a query at q against the current table and count
   function automatic rsp_type interpolate(logic signed [DATA_W-1:0] q);
      int unsigned n, l, r;
      longint xl, xr, yl, yr, dx, dy, slope, total;
      logic signed [95:0] offset, slope_w, prod, term;
      bit sat;
      rsp_type answer;
      n = point_count;
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      l = n - 2;
      r = n - 1;
      for (int k = 1; k + 1 < n; k++) begin
         if (q < abscissa_table[k]) begin
            l = k - 1;
            r = k;
            break;
         end
      end
      xl = abscissa_table[l];
      xr = abscissa_table[r];
      yl = ordinate_table[l];
      yr = ordinate_table[r];
      dx = xr - xl;
      dy = yr - yl;
      sat = 0;
      if (dx == 0) begin
         slope = (dy > 0) ? S32_MAX : ((dy < 0) ? S32_MIN : 0);
         total = yl;
         answer.status = STATUS_ZERO;
      end else begin
         slope = (dy * (64'sd1 << FRAC_BITS)) / dx;
         if (slope > S32_MAX) begin
            slope = S32_MAX;
            sat = 1;
         end else if (slope < S32_MIN) begin
            slope = S32_MIN;
            sat = 1;
         end
         // product can exceed 64 bits, so work wide
         offset  = longint'(q) - xl;
         slope_w = slope;
         prod    = offset * slope_w;
         term    = prod >>> FRAC_BITS;
         if (term > TERM_LIM) term = TERM_LIM;
         if (term < -TERM_LIM) term = -TERM_LIM;
         total = yl + longint'(term);
         if (total > S32_MAX) begin
            total = S32_MAX;
            sat = 1;
         end else if (total < S32_MIN) begin
            total = S32_MIN;
            sat = 1;
         end
         answer.status = sat ? STATUS_SAT : STATUS_OK;
      end
      answer.value = total[DATA_W-1:0];
      answer.slope = slope[DATA_W-1:0];
      return answer;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         point_count = 2;
         pending_answers.delete();
      end else begin
         if (csr_we) point_count = csr_wdata;
         if (req_valid && !req_stall) begin
            if (req_data.command == CMD_WRITE) begin
               abscissa_table[req_data.point_index] = req_data.abscissa;
               ordinate_table[req_data.point_index] = req_data.ordinate;
            end else begin
               pending_answers.push_back(interpolate(req_data.abscissa));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               error_count = error_count + 1;
               $display("%0t: unexpected response value=%0d slope=%0d status=%0d",
                        $time, rsp_data.value, rsp_data.slope, rsp_data.status);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.value !== want.value) begin
                  error_count = error_count + 1;
                  $display("%0t: value expected %0d actual %0d",
                           $time, want.value, rsp_data.value);
               end
               if (rsp_data.slope !== want.slope) begin
                  error_count = error_count + 1;
                  $display("%0t: slope expected %0d actual %0d",
                           $time, want.slope, rsp_data.slope);
               end
               if (rsp_data.status !== want.status) begin
                  error_count = error_count + 1;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
               end
            end
         end
      end
      answers_owed = pending_answers.size();
   end

   initial begin
      error_count  = 0;
      answers_owed = 0;
   end

endmodule

### sim/piecewise_linear_interpolator_tb.sv
// testbench top: clock, reset, stimulus and verdict for the interpolator
`timescale 1ns / 1ps
module piecewise_linear_interpolator_tb;
   import pli_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [CNT_W-1:0] csr_wdata;
   int               error_count;
   int               answers_owed;

   // stimulus-side copy of the abscissas, only used to aim queries
   logic signed [DATA_W-1:0] aim_abscissa [MAX_POINTS];
   int                       transactions_sent;
   int                       active_points;
   bit                       hold_rsp;

   piecewise_linear_interpolator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   pli_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .answers_owed (answers_owed)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // no idling on either side in this window of the run
   function automatic bit calm_window();
      return transactions_sent >= 900 && transactions_sent < 1150;
   endfunction

   // receiver: random stalls, plus one long hold-off so the block backs up its input
   initial begin
      int hold_cycles;
      rsp_stall = 1;
      hold_rsp  = 0;
      hold_cycles = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_rsp && transactions_sent >= 600 && hold_cycles == 0) begin
            hold_rsp    = 1;
            hold_cycles = 1;
         end
         if (hold_rsp) begin
            rsp_stall   <= 1;
            hold_cycles = hold_cycles + 1;
            if (hold_cycles > 2000) hold_rsp = 0;
         end else if (calm_window()) begin
            rsp_stall <= 0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 34);
         end
         @(posedge clock);
      end
   end

   // one transaction: random idle cycles first (none in the calm window), then hold until accepted
   task automatic send(req_type item);
      while (!calm_window() && $urandom_range(0, 99) < 34) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      transactions_sent = transactions_sent + 1;
      if (item.command == CMD_WRITE) aim_abscissa[item.point_index] = item.abscissa;
   endtask

   task automatic write_point(int slot, logic signed [31:0] x, logic signed [31:0] y);
      req_type item;
      item.command     = CMD_WRITE;
      item.point_index = slot[IDX_W-1:0];
      item.abscissa    = x;
      item.ordinate    = y;
      send(item);
   endtask

   task automatic query(logic signed [31:0] q);
      req_type item;
      item.command     = CMD_QUERY;
      item.point_index = IDX_W'($urandom());
      item.abscissa    = q;
      item.ordinate    = $urandom();
      send(item);
   endtask

   // register write only once every response is in and the block has settled
   task automatic set_point_count(int count);
      req_valid <= 0;
      repeat (2) @(posedge clock);
      while (answers_owed != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_we    <= 1;
      csr_wdata <= count[CNT_W-1:0];
      @(posedge clock);
      csr_we    <= 0;
      active_points = (count < 2) ? 2 : ((count > MAX_POINTS) ? MAX_POINTS : count);
   endtask

   // rewrite slots 0 .. count-1, ascending unless scrambled
   task automatic load_table(int count, bit scrambled);
      longint x;
      int     reach;
      reach = $urandom_range(0, 22);
      x = $signed($urandom()) >>> $urandom_range(0, 31);
      for (int k = 0; k < count; k++) begin
         if (scrambled) begin
            x = $signed($urandom()) >>> $urandom_range(0, 31);
         end else if (k > 0) begin
            // an occasional repeated abscissa gives a zero-width interval
            if ($urandom_range(0, 19) != 0) x = x + $urandom_range(1, 1 << reach);
            if (x > 64'sd2147483647) x = 64'sd2147483647;
         end
         write_point(k, x[31:0],
                     ($urandom_range(0, 3) == 0) ? $urandom() :
                     ($signed($urandom()) >>> $urandom_range(8, 31)));
      end
   endtask

   // query mostly inside or just beyond the table span, sometimes anywhere
   task automatic aimed_query();
      longint lo, hi, q;
      int     pick;
      lo = aim_abscissa[0];
      hi = aim_abscissa[active_points - 1];
      if (lo > hi) begin
         q = lo; lo = hi; hi = q;
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         q = lo - (hi - lo) / 8 + longint'($urandom()) % ((hi - lo) + (hi - lo) / 4 + 1);
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         query(q[31:0]);
      end else if (pick < 8) begin
         query(aim_abscissa[$urandom_range(0, active_points - 1)]);
      end else begin
         query($urandom());
      end
   endtask

   initial begin
      int count;
      reset     = 1;
      req_valid = 0;
      req_data  = '0;
      csr_we    = 0;
      csr_wdata = '0;
      transactions_sent = 0;
      active_points = 2;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // whole table written once so no query ever reads an unwritten slot
      for (int k = 0; k < MAX_POINTS; k++)
         write_point(k, (k - 128) * 32'sd65536, $urandom());

      // two points after reset: extrapolation at both extremes
      query(32'sh8000_0000);
      query(32'sh7FFF_FFFF);
      query(32'sd0);

      // full table, then counts outside the legal range
      set_point_count(MAX_POINTS);
      query(32'sh8000_0000);
      query(32'sh7FFF_FFFF);
      query(32'sd65536);
      set_point_count(0);
      query(32'sd1);
      set_point_count(511);
      query(32'sh7FFF_FFFF);

      // zero-width interval with rising, falling and flat ordinate
      set_point_count(2);
      write_point(0, 32'sd100, 32'sd5);
      write_point(1, 32'sd100, 32'sd9);
      query(32'sd0);
      write_point(1, 32'sd100, -32'sd9);
      query(32'sd200);
      write_point(1, 32'sd100, 32'sd5);
      query(32'sd100);

      // steep interval saturates slope and value
      write_point(0, 32'sd0, 32'sh8000_0000);
      write_point(1, 32'sd1, 32'sh7FFF_FFFF);
      query(32'sh7FFF_FFFF);
      query(32'sh8000_0000);

      // random phases: new count, fresh table, then a burst of queries
      while (transactions_sent < 1850) begin
         case ($urandom_range(0, 19))
            0:       count = MAX_POINTS;
            1:       count = $urandom_range(0, 1);
            2:       count = $urandom_range(MAX_POINTS + 1, 511);
            3:       count = 2;
            default: count = $urandom_range(3, 24);
         endcase
         set_point_count(count);
         load_table(active_points, $urandom_range(0, 9) == 0);
         for (int k = 0; k < ((active_points > 64) ? 4 : $urandom_range(8, 30)); k++) begin
            // now and then a stray write may break the ordering of the table
            if ($urandom_range(0, 15) == 0)
               write_point($urandom_range(0, MAX_POINTS - 1), $urandom(), $urandom());
            aimed_query();
         end
      end

      req_valid <= 0;
      @(posedge clock);
      while (answers_owed != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule

### files.f
rtl/pli_pkg.sv
rtl/pli_div_cell.sv
rtl/pli_div_chain.sv
rtl/piecewise_linear_interpolator.sv
sim/pli_checker.sv
sim/piecewise_linear_interpolator_tb.sv
